/* design/inv_ncdf_pkg.sv */
// inv_ncdf_pkg: fixed-point constants, coefficient table and multiply helpers
// for the inverse normal CDF pipeline. No dependencies.
package inv_ncdf_pkg;

    // internal fixed point: Q56 values, Q46 coefficients
    localparam int QI = 56;
    localparam int QC = 46;

    localparam int LOG_STEPS    = 56;
    localparam int SQ_STEPS     = 60;
    localparam int HORNER_STEPS = 7;
    localparam int DIV_STEPS    = 64;

    localparam logic [63:0]  LN2_Q64 = 64'hB17217F7D1CF79AC;
    localparam logic [127:0] TEN19   = 128'd10000000000000000000;
    localparam logic [127:0] HALF19  = 128'd5000000000000000000;

    // 0.180625, 1.6 and 5.0 in Q56
    localparam logic [63:0] R0_Q56   = 64'((64'd289 << 50) / 64'd25);
    localparam logic [63:0] C16_Q56  = 64'((64'd8 << QI) / 64'd5);
    localparam logic [63:0] FIVE_Q56 = 64'd5 << QI;

    localparam logic [1:0] RGN_CENTRAL = 2'd0;
    localparam logic [1:0] RGN_MIDDLE  = 2'd1;
    localparam logic [1:0] RGN_FAR     = 2'd2;

    localparam int LANE_NUM = 0;
    localparam int LANE_DEN = 1;

    typedef struct packed {
        logic [63:0] p11;
        logic [63:0] p10;
        logic [63:0] p01;
        logic [63:0] p00;
    } pp4_t;

    // integer part plus 19 decimal fraction digits -> Q46, rounded to nearest
    function automatic logic [63:0] coef_q46(input logic [63:0] ip, input logic [63:0] fr);
        logic [127:0] w;
        begin
            w = ({64'd0, fr} << QC) + HALF19;
            return (ip << QC) + 64'(w / TEN19);
        end
    endfunction

    // 64x64 product as four 32x32 partial products
    function automatic pp4_t mul_parts(input logic [63:0] a, input logic [63:0] b);
        pp4_t pp;
        begin
            pp.p00 = 64'(a[31:0]) * 64'(b[31:0]);
            pp.p01 = 64'(a[31:0]) * 64'(b[63:32]);
            pp.p10 = 64'(a[63:32]) * 64'(b[31:0]);
            pp.p11 = 64'(a[63:32]) * 64'(b[63:32]);
            return pp;
        end
    endfunction

    function automatic logic [127:0] sum_parts(input pp4_t pp);
        begin
            return {pp.p11, 64'd0} + {32'd0, pp.p01, 32'd0}
                 + {32'd0, pp.p10, 32'd0} + {64'd0, pp.p00};
        end
    endfunction

    // [region][numerator/denominator][power]
    localparam logic [63:0] COEF [3][2][8] = '{
        '{
            '{coef_q46(64'd3, 64'd3871328727963666080),
              coef_q46(64'd133, 64'd1416678917843774500),
              coef_q46(64'd1971, 64'd5909503065514427000),
              coef_q46(64'd13731, 64'd6937655094611250000),
              coef_q46(64'd45921, 64'd9539315498714570000),
              coef_q46(64'd67265, 64'd7709270087008530000),
              coef_q46(64'd33430, 64'd5755835881281050000),
              coef_q46(64'd2509, 64'd809287301226727000)},
            '{coef_q46(64'd1, 64'd0),
              coef_q46(64'd42, 64'd3133307016009112520),
              coef_q46(64'd687, 64'd1870074920579083000),
              coef_q46(64'd5394, 64'd1960214247511077000),
              coef_q46(64'd21213, 64'd7943015865958670000),
              coef_q46(64'd39307, 64'd8958000927106100000),
              coef_q46(64'd28729, 64'd857357219426740000),
              coef_q46(64'd5226, 64'd4952788528545610000)}
        },
        '{
            '{coef_q46(64'd1, 64'd4234371107496835773),
              coef_q46(64'd4, 64'd6303378461565452959),
              coef_q46(64'd5, 64'd7694972214606914055),
              coef_q46(64'd3, 64'd6478483247632046050),
              coef_q46(64'd1, 64'd2704582524523683825),
              coef_q46(64'd0, 64'd2417807251774506117),
              coef_q46(64'd0, 64'd227238449892691845),
              coef_q46(64'd0, 64'd7745450142783414)},
            '{coef_q46(64'd1, 64'd0),
              coef_q46(64'd2, 64'd531916266377588218),
              coef_q46(64'd1, 64'd6763848301838038494),
              coef_q46(64'd0, 64'd6897673349851000045),
              coef_q46(64'd0, 64'd1481039764274800745),
              coef_q46(64'd0, 64'd151986665636164571),
              coef_q46(64'd0, 64'd5475938084995344),
              coef_q46(64'd0, 64'd10507500716)}
        },
        '{
            '{coef_q46(64'd6, 64'd6579046435011037772),
              coef_q46(64'd5, 64'd4637849111641143699),
              coef_q46(64'd1, 64'd7848265399172913358),
              coef_q46(64'd0, 64'd2965605718285048912),
              coef_q46(64'd0, 64'd265321895265761230),
              coef_q46(64'd0, 64'd12426609473880784),
              coef_q46(64'd0, 64'd271155556874348),
              coef_q46(64'd0, 64'd2010334399292)},
            '{coef_q46(64'd1, 64'd0),
              coef_q46(64'd0, 64'd5998322065558879376),
              coef_q46(64'd0, 64'd1369298809227358053),
              coef_q46(64'd0, 64'd148753612908506148),
              coef_q46(64'd0, 64'd7868691311456132),
              coef_q46(64'd0, 64'd184631831751005),
              coef_q46(64'd0, 64'd1421511758316),
              coef_q46(64'd0, 64'd20442)}
        }
    };

endpackage

/* design/inverse_normal_cdf.sv */
// inverse_normal_cdf: pipelined AS241 inverse standard normal CDF.
// Uses inv_ncdf_pkg (constants, coefficient table, multiply helpers).
//
// Usage
//   Input beat : p_valid / p_stall, payload p_fraction = p * 2^IN_FRAC_BITS
//                (2^IN_FRAC_BITS means p = 1).
//   Output beat: z_valid / z_stall, payload z_value = z * 2^OUT_FRAC_BITS
//                (two's complement) and fault (p was 0 or >= 1, z forced to 0).
//   Depth      : set mainly by the 56-step log2 squaring chain (two
//                stages per step), the 60-step square root and the 64-step
//                restoring divider; each root and divider stage does one step.
//   Throughput : one beat per cycle while no held result stalls the pipe.
//   Stall      : while a result waits with z_stall high the whole pipe holds;
//                p_stall is high exactly then. Nothing is lost or repeated.
//   Reset      : rst_n clears all valid bits; the pipe comes up empty and
//                p_stall low.
// Every item passes the log/sqrt stages; central-region items ignore them
// and use the r value computed up front.
module inverse_normal_cdf #(
    parameter int IN_FRAC_BITS  = 32,
    parameter int OUT_FRAC_BITS = 28
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    p_valid,
    output logic                    p_stall,
    input  logic [IN_FRAC_BITS:0]   p_fraction,
    output logic                    z_valid,
    input  logic                    z_stall,
    output logic [31:0]             z_value,
    output logic                    fault
);

    localparam int IN_W = IN_FRAC_BITS + 1;
    localparam int EW   = $clog2(IN_W);
    localparam int QI   = inv_ncdf_pkg::QI;
    localparam int LOGN = inv_ncdf_pkg::LOG_STEPS;
    localparam int SQN  = inv_ncdf_pkg::SQ_STEPS;
    localparam int HN   = inv_ncdf_pkg::HORNER_STEPS;
    localparam int DVN  = inv_ncdf_pkg::DIV_STEPS;

    // stage indices (register written at that stage)
    localparam int ST_A   = 0;              // decode p
    localparam int ST_B   = 1;              // leading one, q^2 partials
    localparam int ST_C   = 2;              // normalize, q^2 sum
    localparam int ST_D   = 3;              // r for central region
    localparam int LOG0   = 4;              // log2 squaring chain
    localparam int LB_ST  = LOG0 + 2 * LOGN;
    localparam int YP_ST  = LB_ST + 1;      // -log2 * ln2 partials
    localparam int YS_ST  = YP_ST + 1;
    localparam int SQ0    = YS_ST + 1;      // square root digits
    localparam int TS_ST  = SQ0 + SQN;      // region pick, Horner load
    localparam int HN0    = TS_ST + 1;
    localparam int NP_ST  = HN0 + 2 * HN;   // numerator partials
    localparam int NS_ST  = NP_ST + 1;
    localparam int DV0    = NS_ST + 1;      // divider
    localparam int OUT_ST = DV0 + DVN;

    localparam int SHIFT = QI - OUT_FRAC_BITS;
    localparam logic [64:0] RND_HALF =
        (SHIFT > 0) ? (65'd1 << ((SHIFT > 0) ? (SHIFT - 1) : 0)) : 65'd0;

    localparam logic [IN_W-1:0]   ONE_P  = IN_W'(1) << IN_FRAC_BITS;
    localparam logic [IN_W-1:0]   HALF_P = IN_W'(1) << (IN_FRAC_BITS - 1);
    localparam logic [IN_W+6:0]   LIM_C  = (IN_W + 7)'(17) << IN_FRAC_BITS;

    typedef struct packed {
        logic            neg;
        logic            fault;
        logic [1:0]      region;
        logic [IN_W-1:0] qx;
        logic [63:0]     r;
        logic [6:0]      lint;
    } side_t;

    logic  adv;
    logic  vld_reg [0:OUT_ST];
    side_t side_reg  [0:OUT_ST-1];
    side_t side_next [0:OUT_ST-1];

    // pipe moves unless a finished result is held by the receiver
    assign adv     = ~vld_reg[OUT_ST] | ~z_stall;
    assign p_stall = ~adv;
    assign z_valid = vld_reg[OUT_ST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= OUT_ST; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= p_valid;
            for (int k = 1; k <= OUT_ST; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // ---------------- front end ----------------
    logic [IN_W-1:0] rx_a_reg, rx_b_reg;
    logic [EW-1:0]   e_b_reg;
    inv_ncdf_pkg::pp4_t qq_b_reg;
    logic [63:0]     m_c_reg, sq_c_reg;

    logic [IN_W-1:0] a_qx, a_rx;
    logic            a_neg, a_central;
    logic [EW-1:0]   b_e;
    logic [63:0]     b_qm, c_m, c_sq, d_r;
    logic [127:0]    c_sum;
    logic [6:0]      c_lint;

    always_comb
    begin
        a_neg     = p_fraction < HALF_P;
        a_qx      = a_neg ? (HALF_P - p_fraction) : (p_fraction - HALF_P);
        a_central = (((IN_W + 7)'(a_qx) << 5) + ((IN_W + 7)'(a_qx) << 3)) <= LIM_C;
        if (a_neg)
            a_rx = p_fraction;
        else if (p_fraction >= ONE_P)
            a_rx = '0;
        else
            a_rx = ONE_P - p_fraction;

        b_e = '0;
        for (int b = 0; b < IN_W; b++)
            if (rx_a_reg[b])
                b_e = EW'(b);
        b_qm = 64'(side_reg[ST_A].qx) << (QI - IN_FRAC_BITS);

        c_m    = 64'(rx_b_reg) << (7'd62 - 7'(e_b_reg));
        c_lint = 7'(IN_FRAC_BITS) - 7'(e_b_reg);
        c_sum  = inv_ncdf_pkg::sum_parts(qq_b_reg);
        c_sq   = c_sum[119:56];

        d_r = (sq_c_reg < inv_ncdf_pkg::R0_Q56) ? (inv_ncdf_pkg::R0_Q56 - sq_c_reg) : 64'd0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rx_a_reg <= a_rx;
            rx_b_reg <= rx_a_reg;
            e_b_reg  <= b_e;
            qq_b_reg <= inv_ncdf_pkg::mul_parts(b_qm, b_qm);
            m_c_reg  <= c_m;
            sq_c_reg <= c_sq;
        end
    end

    // ---------------- -log2 by repeated squaring ----------------
    logic [63:0]        lgm_reg [0:LOGN];
    logic [55:0]        lgf_reg [0:LOGN];
    inv_ncdf_pkg::pp4_t lpp_reg [0:LOGN-1];
    logic [55:0]        lfa_reg [0:LOGN-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lgm_reg[0] <= m_c_reg;
            lgf_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < LOGN; i++)
    begin : g_log
        logic [127:0] sq;
        logic [63:0]  mn;
        logic [55:0]  fn;
        always_comb
        begin
            sq = inv_ncdf_pkg::sum_parts(lpp_reg[i]);
            mn = sq[125:62];
            fn = lfa_reg[i];
            if (mn[63])
            begin
                mn = mn >> 1;
                fn[55-i] = 1'b1;
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                lpp_reg[i]   <= inv_ncdf_pkg::mul_parts(lgm_reg[i], lgm_reg[i]);
                lfa_reg[i]   <= lgf_reg[i];
                lgm_reg[i+1] <= mn;
                lgf_reg[i+1] <= fn;
            end
        end
    end

    // ---------------- ln, square root ----------------
    logic [63:0]        lb_reg;
    inv_ncdf_pkg::pp4_t yp_reg;
    logic [63:0]        lb_full;
    logic [127:0]       y_sum;

    logic [119:0] sq_rad_reg  [0:SQN];
    logic [61:0]  sq_rem_reg  [0:SQN];
    logic [59:0]  sq_root_reg [0:SQN];

    always_comb
    begin
        lb_full = {1'b0, side_reg[LB_ST-1].lint, 56'd0};
        y_sum   = inv_ncdf_pkg::sum_parts(yp_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lb_reg <= (lb_full > {8'd0, lgf_reg[LOGN]}) ?
                      (lb_full - {8'd0, lgf_reg[LOGN]}) : 64'd0;
            yp_reg <= inv_ncdf_pkg::mul_parts(lb_reg, inv_ncdf_pkg::LN2_Q64);
            sq_rad_reg[0]  <= {y_sum[127:64], 56'd0};
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    for (genvar j = 0; j < SQN; j++)
    begin : g_sqrt
        logic [63:0] rem2, trial;
        logic        ge;
        always_comb
        begin
            rem2  = {sq_rem_reg[j], sq_rad_reg[j][119:118]};
            trial = {2'b00, sq_root_reg[j], 2'b01};
            ge    = rem2 >= trial;
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_rad_reg[j+1]  <= sq_rad_reg[j] << 2;
                sq_rem_reg[j+1]  <= ge ? 62'(rem2 - trial) : 62'(rem2);
                sq_root_reg[j+1] <= {sq_root_reg[j][58:0], ge};
            end
        end
    end

    // ---------------- region pick, Horner ----------------
    logic [63:0] ts_s, ts_t, ts_v;
    logic [1:0]  ts_rgn;

    logic [63:0]        hv_reg   [0:HN];
    logic [63:0]        accn_reg [0:HN];
    logic [63:0]        accd_reg [0:HN];
    logic [63:0]        hva_reg  [0:HN-1];
    inv_ncdf_pkg::pp4_t hpn_reg  [0:HN-1];
    inv_ncdf_pkg::pp4_t hpd_reg  [0:HN-1];

    always_comb
    begin
        ts_s = 64'(sq_root_reg[SQN]);
        if (ts_s <= inv_ncdf_pkg::FIVE_Q56)
        begin
            ts_t   = (ts_s > inv_ncdf_pkg::C16_Q56) ? (ts_s - inv_ncdf_pkg::C16_Q56) : 64'd0;
            ts_rgn = inv_ncdf_pkg::RGN_MIDDLE;
        end
        else
        begin
            ts_t   = ts_s - inv_ncdf_pkg::FIVE_Q56;
            ts_rgn = inv_ncdf_pkg::RGN_FAR;
        end
        if (side_reg[TS_ST-1].region == inv_ncdf_pkg::RGN_CENTRAL)
        begin
            ts_v   = side_reg[TS_ST-1].r;
            ts_rgn = inv_ncdf_pkg::RGN_CENTRAL;
        end
        else
            ts_v = ts_t;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hv_reg[0]   <= ts_v;
            accn_reg[0] <= inv_ncdf_pkg::COEF[ts_rgn][inv_ncdf_pkg::LANE_NUM][7];
            accd_reg[0] <= inv_ncdf_pkg::COEF[ts_rgn][inv_ncdf_pkg::LANE_DEN][7];
        end
    end

    for (genvar k = 0; k < HN; k++)
    begin : g_horner
        logic [127:0] sn, sd;
        logic [1:0]   rg;
        always_comb
        begin
            sn = inv_ncdf_pkg::sum_parts(hpn_reg[k]);
            sd = inv_ncdf_pkg::sum_parts(hpd_reg[k]);
            rg = side_reg[HN0 + 2 * k].region;
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                hpn_reg[k]    <= inv_ncdf_pkg::mul_parts(accn_reg[k], hv_reg[k]);
                hpd_reg[k]    <= inv_ncdf_pkg::mul_parts(accd_reg[k], hv_reg[k]);
                hva_reg[k]    <= hv_reg[k];
                hv_reg[k+1]   <= hva_reg[k];
                accn_reg[k+1] <= sn[119:56] + inv_ncdf_pkg::COEF[rg][inv_ncdf_pkg::LANE_NUM][6-k];
                accd_reg[k+1] <= sd[119:56] + inv_ncdf_pkg::COEF[rg][inv_ncdf_pkg::LANE_DEN][6-k];
            end
        end
    end

    // ---------------- numerator, divider ----------------
    inv_ncdf_pkg::pp4_t np_reg;
    logic [63:0]        npn_reg, npd_reg;
    logic [63:0]        np_qm;
    logic [127:0]       ns_num;

    logic [63:0] dv_rem_reg [0:DVN];
    logic [63:0] dv_lo_reg  [0:DVN];
    logic [63:0] dv_q_reg   [0:DVN];
    logic [63:0] dv_d_reg   [0:DVN];

    always_comb
    begin
        np_qm = 64'(side_reg[NP_ST-1].qx) << (QI - IN_FRAC_BITS);
        if (side_reg[NS_ST-1].region == inv_ncdf_pkg::RGN_CENTRAL)
            ns_num = inv_ncdf_pkg::sum_parts(np_reg);
        else
            ns_num = {64'd0, npn_reg} << QI;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            np_reg        <= inv_ncdf_pkg::mul_parts(np_qm, accn_reg[HN]);
            npn_reg       <= accn_reg[HN];
            npd_reg       <= accd_reg[HN];
            dv_rem_reg[0] <= ns_num[127:64];
            dv_lo_reg[0]  <= ns_num[63:0];
            dv_q_reg[0]   <= '0;
            dv_d_reg[0]   <= npd_reg;
        end
    end

    for (genvar j = 0; j < DVN; j++)
    begin : g_div
        logic [64:0] r65, diff;
        logic        ge;
        always_comb
        begin
            r65  = {dv_rem_reg[j], dv_lo_reg[j][63]};
            diff = r65 - {1'b0, dv_d_reg[j]};
            ge   = r65 >= {1'b0, dv_d_reg[j]};
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_rem_reg[j+1] <= ge ? diff[63:0] : r65[63:0];
                dv_lo_reg[j+1]  <= dv_lo_reg[j] << 1;
                dv_q_reg[j+1]   <= {dv_q_reg[j][62:0], ge};
                dv_d_reg[j+1]   <= dv_d_reg[j];
            end
        end
    end

    // ---------------- round, saturate, sign ----------------
    logic [64:0] o_sum, o_mag;
    logic [31:0] o_z;
    logic [31:0] z_value_reg;
    logic        fault_reg;

    always_comb
    begin
        o_sum = {1'b0, dv_q_reg[DVN]} + RND_HALF;
        o_mag = o_sum >> SHIFT;
        if (side_reg[OUT_ST-1].neg)
        begin
            if (o_mag > 65'h80000000)
                o_mag = 65'h80000000;
            o_z = 32'd0 - o_mag[31:0];
        end
        else
        begin
            if (o_mag > 65'h7FFFFFFF)
                o_mag = 65'h7FFFFFFF;
            o_z = o_mag[31:0];
        end
        if (side_reg[OUT_ST-1].fault)
            o_z = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            z_value_reg <= o_z;
            fault_reg   <= side_reg[OUT_ST-1].fault;
        end
    end

    assign z_value = z_value_reg;
    assign fault   = fault_reg;

    // ---------------- per-item side info ----------------
    always_comb
    begin
        side_next[0].neg    = a_neg;
        side_next[0].fault  = 1'b0;
        side_next[0].region = a_central ? inv_ncdf_pkg::RGN_CENTRAL : inv_ncdf_pkg::RGN_MIDDLE;
        side_next[0].qx     = a_qx;
        side_next[0].r      = '0;
        side_next[0].lint   = '0;
        for (int k = 1; k < OUT_ST; k++)
            side_next[k] = side_reg[k-1];
        side_next[ST_B].fault = (rx_a_reg == '0) &&
                                (side_reg[ST_A].region != inv_ncdf_pkg::RGN_CENTRAL);
        side_next[ST_C].lint  = c_lint;
        side_next[ST_D].r     = d_r;
        side_next[TS_ST].region = ts_rgn;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < OUT_ST; k++)
                side_reg[k] <= side_next[k];
        end
    end

endmodule

/* design/inv_ncdf_checker.sv */
// inv_ncdf_checker: port-level assertions for inverse_normal_cdf, bound below.
// Depends only on the top level's ports.
module inv_ncdf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        p_valid,
    input logic        p_stall,
    input logic        z_valid,
    input logic        z_stall,
    input logic [31:0] z_value,
    input logic        fault
);

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        z_valid && z_stall |=> z_valid && $stable(z_value) && $stable(fault))
        else $error("output beat changed while stalled");

    // faulted beats carry zero
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        z_valid && fault |-> z_value == 32'd0)
        else $error("fault beat with nonzero z");

    // input side only backs up when a result is held
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        p_stall |-> z_valid && z_stall)
        else $error("input stalled without output backpressure");

endmodule

bind inverse_normal_cdf inv_ncdf_checker u_inv_ncdf_checker (.*);
